// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the cache tag store.
// Both macros expect a clock named i_clk in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define SALWC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SALWC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/salwc_pkg.sv
// Shared types and constants of the set-associative write-back cache.
// Used by every module of the block; depends on nothing.
package salwc_pkg;

    localparam int SET_COUNT_DEF = 256;
    localparam int WAY_COUNT_DEF = 4;
    localparam int ADDR_W        = 32;
    localparam int CNT_W         = 32;
    localparam int CFG_W         = 4;
    localparam int SET_IDX_W     = 8;   // wide enough for the largest set count
    localparam int REM_W         = 15;  // widest masked index field
    localparam int RED_W         = 24;  // holds the set count shifted by up to 14

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic CFG_INDEX_BITS  = 1'b0;
    localparam logic CFG_OFFSET_BITS = 1'b1;

    localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd6;
    localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd5;

    typedef struct packed {
        logic                 op;
        logic [ADDR_W-1:0]    addr;
        logic [SET_IDX_W-1:0] set;
        logic [ADDR_W-1:0]    tag;
    } t_access;

    typedef enum logic [1:0] {
        F_IDLE,
        F_RED_HI,
        F_RED_LO,
        F_PUSH
    } t_front_state;

    typedef enum logic {
        B_IDLE,
        B_EVAL
    } t_back_state;

endpackage

// File: rtl/salwc_front.sv
// Front end: accepts an access, extracts tag and set index, hands it to the queue.
// Depends on salwc_pkg.
module salwc_front import salwc_pkg::*; #(
    parameter int SET_COUNT = SET_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_set_bits,
    input  logic [CFG_W-1:0] i_offset_bits,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_operation,
    input  logic [ADDR_W-1:0] i_address,
    output logic             o_push,
    output t_access          o_item,
    input  logic             i_full
);

    localparam logic [RED_W-1:0] SET_EXT = RED_W'(SET_COUNT);

    t_front_state r_state, n_state;
    logic             r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_tag;
    logic [REM_W-1:0]  r_rem, n_rem;

    logic [ADDR_W-1:0] shifted;
    logic [REM_W-1:0]  mask;
    logic [4:0]        tag_shift;
    logic              accept;

    assign o_stall = (r_state != F_IDLE);
    assign accept  = i_valid && (r_state == F_IDLE);

    assign shifted   = i_address >> i_offset_bits;
    assign mask      = REM_W'((16'd1 << i_set_bits) - 16'd1);
    assign tag_shift = 5'(i_set_bits) + 5'(i_offset_bits);

    // Remainder by the set count: shift-and-subtract over bit positions 14 to 7 in F_RED_HI and 6 to 0 in F_RED_LO.
    always_comb begin
        int k;
        logic [RED_W-1:0] acc;
        acc = RED_W'(r_rem);
        for (int j = 0; j < 8; j++) begin
            k = (r_state == F_RED_LO) ? (6 - j) : (14 - j);
            if (k >= 0) begin
                if (acc >= (SET_EXT << k)) begin
                    acc = acc - (SET_EXT << k);
                end
            end
        end
        n_rem = acc[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_addr <= i_address;
            r_tag  <= i_address >> tag_shift;
            r_rem  <= shifted[REM_W-1:0] & mask;
        end else if (r_state == F_RED_HI || r_state == F_RED_LO) begin
            r_rem <= n_rem;
        end
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = F_RED_HI;
                end
            end
            F_RED_HI: n_state = F_RED_LO;
            F_RED_LO: n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    assign o_item.op   = r_op;
    assign o_item.addr = r_addr;
    assign o_item.set  = r_rem[SET_IDX_W-1:0];
    assign o_item.tag  = r_tag;

endmodule

// File: rtl/salwc_queue.sv
// Two-entry queue of classified accesses between the front and back ends.
// Depends on salwc_pkg.
module salwc_queue import salwc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_access i_item,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_access o_head
);

    t_access    r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: rtl/salwc_back.sv
// Back end: reads a set, resolves hit and LRU victim, updates the set and counters.
// Depends on salwc_pkg; holds the tag, address and line state memories.
module salwc_back import salwc_pkg::*; #(
    parameter int SET_COUNT = SET_COUNT_DEF,
    parameter int WAY_COUNT = WAY_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_access           i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_hit,
    output logic              o_fill_request,
    output logic [ADDR_W-1:0] o_fill_address,
    output logic              o_writeback_request,
    output logic [ADDR_W-1:0] o_writeback_address,
    output logic [CNT_W-1:0]  o_read_count,
    output logic [CNT_W-1:0]  o_read_miss_count,
    output logic [CNT_W-1:0]  o_write_count,
    output logic [CNT_W-1:0]  o_write_miss_count,
    output logic [CNT_W-1:0]  o_writeback_count
);

    localparam int SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int RANK_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(WAY_COUNT - 1);

    logic [WAY_COUNT-1:0][ADDR_W-1:0] tag_mem   [SET_COUNT];
    logic [WAY_COUNT-1:0][ADDR_W-1:0] addr_mem  [SET_COUNT];
    logic [WAY_COUNT-1:0]             valid_mem [SET_COUNT];
    logic [WAY_COUNT-1:0]             dirty_mem [SET_COUNT];
    logic [WAY_COUNT-1:0][RANK_W-1:0] rank_mem  [SET_COUNT];
    logic [SET_COUNT-1:0]             r_set_init;

    t_back_state r_state, n_state;
    t_access     r_item;
    logic [SET_W-1:0] r_set;

    logic [WAY_COUNT-1:0][ADDR_W-1:0] r_rd_tag, r_rd_addr;
    logic [WAY_COUNT-1:0]             r_rd_valid, r_rd_dirty;
    logic [WAY_COUNT-1:0][RANK_W-1:0] r_rd_rank;
    logic                             r_rd_init;

    logic [CNT_W-1:0] r_cnt_rd, r_cnt_rd_miss, r_cnt_wr, r_cnt_wr_miss, r_cnt_wb;

    logic [WAY_COUNT-1:0]             cur_valid, cur_dirty, n_valid, n_dirty;
    logic [WAY_COUNT-1:0][RANK_W-1:0] cur_rank, n_rank;
    logic [WAY_COUNT-1:0][ADDR_W-1:0] n_tag_row, n_addr_row;
    logic [RANK_W-1:0] way, hit_way, victim_way;
    logic              hit, hit_found, victim_found, wb;
    logic [SET_W-1:0]  head_set;
    logic              commit;

    assign head_set = i_head.set[SET_W-1:0];
    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign commit   = (r_state == B_EVAL) && (!o_valid || !i_stall);

    // A set that was never written reads as the reset state: no valid lines,
    // ranks equal to way numbers.
    always_comb begin
        for (int w = 0; w < WAY_COUNT; w++) begin
            cur_valid[w] = r_rd_init && r_rd_valid[w];
            cur_dirty[w] = r_rd_init && r_rd_dirty[w];
            cur_rank[w]  = r_rd_init ? r_rd_rank[w] : RANK_W'(w);
        end
    end

    always_comb begin
        hit_found    = 1'b0;
        victim_found = 1'b0;
        hit_way      = LAST_RANK;
        victim_way   = LAST_RANK;
        for (int w = 0; w < WAY_COUNT; w++) begin
            if (!hit_found && cur_valid[w] && (r_rd_tag[w] == r_item.tag)) begin
                hit_found = 1'b1;
                hit_way   = RANK_W'(w);
            end
            if (!victim_found && (cur_rank[w] == LAST_RANK)) begin
                victim_found = 1'b1;
                victim_way   = RANK_W'(w);
            end
        end
        hit = hit_found;
        way = hit ? hit_way : victim_way;
        wb  = !hit && cur_valid[way] && cur_dirty[way];
    end

    always_comb begin
        n_valid    = cur_valid;
        n_dirty    = cur_dirty;
        n_tag_row  = r_rd_tag;
        n_addr_row = r_rd_addr;
        for (int w = 0; w < WAY_COUNT; w++) begin
            if (RANK_W'(w) == way) begin
                n_rank[w] = '0;
            end else if (cur_rank[w] < cur_rank[way]) begin
                n_rank[w] = cur_rank[w] + RANK_W'(1);
            end else begin
                n_rank[w] = cur_rank[w];
            end
        end
        n_valid[way]    = 1'b1;
        n_dirty[way]    = (r_item.op == OP_WRITE) || (hit && cur_dirty[way]);
        n_tag_row[way]  = r_item.tag;
        n_addr_row[way] = r_item.addr;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = B_EVAL;
                end
            end
            B_EVAL: begin
                if (commit) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= B_IDLE;
            r_set_init    <= '0;
            o_valid       <= 1'b0;
            r_cnt_rd      <= '0;
            r_cnt_rd_miss <= '0;
            r_cnt_wr      <= '0;
            r_cnt_wr_miss <= '0;
            r_cnt_wb      <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_set_init[r_set] <= 1'b1;
                o_valid           <= 1'b1;
                if (r_item.op == OP_WRITE) begin
                    r_cnt_wr <= r_cnt_wr + CNT_W'(1);
                    if (!hit) begin
                        r_cnt_wr_miss <= r_cnt_wr_miss + CNT_W'(1);
                    end
                end else begin
                    r_cnt_rd <= r_cnt_rd + CNT_W'(1);
                    if (!hit) begin
                        r_cnt_rd_miss <= r_cnt_rd_miss + CNT_W'(1);
                    end
                end
                if (wb) begin
                    r_cnt_wb <= r_cnt_wb + CNT_W'(1);
                end
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Result register; counters are reported as they stand after this access.
    always_ff @(posedge i_clk) begin
        if (commit) begin
            o_hit               <= hit;
            o_fill_request      <= !hit;
            o_fill_address      <= hit ? '0 : r_item.addr;
            o_writeback_request <= wb;
            o_writeback_address <= wb ? r_rd_addr[way] : '0;
            o_read_count        <= r_cnt_rd
                                   + CNT_W'(r_item.op == OP_READ);
            o_read_miss_count   <= r_cnt_rd_miss
                                   + CNT_W'((r_item.op == OP_READ) && !hit);
            o_write_count       <= r_cnt_wr
                                   + CNT_W'(r_item.op == OP_WRITE);
            o_write_miss_count  <= r_cnt_wr_miss
                                   + CNT_W'((r_item.op == OP_WRITE) && !hit);
            o_writeback_count   <= r_cnt_wb + CNT_W'(wb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item     <= i_head;
            r_set      <= head_set;
            r_rd_tag   <= tag_mem[head_set];
            r_rd_addr  <= addr_mem[head_set];
            r_rd_valid <= valid_mem[head_set];
            r_rd_dirty <= dirty_mem[head_set];
            r_rd_rank  <= rank_mem[head_set];
            r_rd_init  <= r_set_init[head_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            tag_mem[r_set]   <= n_tag_row;
            addr_mem[r_set]  <= n_addr_row;
            valid_mem[r_set] <= n_valid;
            dirty_mem[r_set] <= n_dirty;
            rank_mem[r_set]  <= n_rank;
        end
    end

endmodule

// File: rtl/set_assoc_lru_writeback_cache_top.sv
// Set-associative write-back, write-allocate cache tag store with true LRU.
// Input channel: i_valid / o_stall with i_operation (0 read, 1 write) and
// i_address. Output channel: o_valid / i_stall with one result per access:
// hit, fill request and address, dirty-victim writeback request and address,
// and five wrapping 32-bit access counters as they stand after the access.
// Configuration: i_cfg_we writes i_cfg_data to the register selected by
// i_cfg_index (0 index bit count, 1 offset bit count). The user must write
// only while the block is idle; the block itself does not enforce this.
// The front end registers an access, takes the set-index remainder in
// F_RED_HI and F_RED_LO and pushes it in F_PUSH once the queue has room; it
// takes no new access until then; the back end reads the set, then updates it.
// Reset clears all line valid and dirty state, sets LRU ranks to way numbers
// and zeroes the counters; no clearing pass is needed.
// When the receiver stalls, the result is held in the output register while
// the back end reads out one more access and waits, and the queue fills; the
// front end then stalls its input.
// Depends on salwc_pkg, salwc_front, salwc_queue, salwc_back, assert_macros.svh.
`include "assert_macros.svh"

module set_assoc_lru_writeback_cache_top import salwc_pkg::*; #(
    parameter int SET_COUNT = SET_COUNT_DEF,
    parameter int WAY_COUNT = WAY_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_operation,
    input  logic [ADDR_W-1:0] i_address,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_hit,
    output logic              o_fill_request,
    output logic [ADDR_W-1:0] o_fill_address,
    output logic              o_writeback_request,
    output logic [ADDR_W-1:0] o_writeback_address,
    output logic [CNT_W-1:0]  o_read_count,
    output logic [CNT_W-1:0]  o_read_miss_count,
    output logic [CNT_W-1:0]  o_write_count,
    output logic [CNT_W-1:0]  o_write_miss_count,
    output logic [CNT_W-1:0]  o_writeback_count
);

    logic [CFG_W-1:0] r_set_bits;
    logic [CFG_W-1:0] r_offset_bits;

    logic    push, pop, full, empty;
    t_access front_item, head_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= INDEX_BITS_RST;
            r_offset_bits <= OFFSET_BITS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INDEX_BITS:  r_set_bits    <= i_cfg_data;
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    salwc_front #(
        .SET_COUNT(SET_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_set_bits   (r_set_bits),
        .i_offset_bits(r_offset_bits),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_address    (i_address),
        .o_push       (push),
        .o_item       (front_item),
        .i_full       (full)
    );

    salwc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (front_item),
        .o_full (full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_head (head_item)
    );

    salwc_back #(
        .SET_COUNT(SET_COUNT),
        .WAY_COUNT(WAY_COUNT)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (empty),
        .i_head             (head_item),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_hit              (o_hit),
        .o_fill_request     (o_fill_request),
        .o_fill_address     (o_fill_address),
        .o_writeback_request(o_writeback_request),
        .o_writeback_address(o_writeback_address),
        .o_read_count       (o_read_count),
        .o_read_miss_count  (o_read_miss_count),
        .o_write_count      (o_write_count),
        .o_write_miss_count (o_write_miss_count),
        .o_writeback_count  (o_writeback_count)
    );

    // A result is either a hit or a miss with a fill, never both.
    `SALWC_ASSERT(a_hit_xor_fill, o_valid |-> (o_hit != o_fill_request), "hit and fill disagree")
    // A dirty eviction only happens on a miss.
    `SALWC_ASSERT(a_wb_needs_miss, (o_valid && o_writeback_request) |-> o_fill_request, "writeback on hit")
    // No result is presented in the cycle after reset.
    `SALWC_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

// File: tb/set_assoc_lru_writeback_cache_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the set-associative LRU write-back cache tag store.
// A behavioral tag store predicts every result; depends on salwc_pkg and the top.
module set_assoc_lru_writeback_cache_top_tb;
    import salwc_pkg::*;

    localparam int SETS = SET_COUNT_DEF;
    localparam int WAYS = WAY_COUNT_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic              hit;
        logic              fill_req;
        logic [ADDR_W-1:0] fill_addr;
        logic              wb_req;
        logic [ADDR_W-1:0] wb_addr;
        logic [CNT_W-1:0]  rd_cnt;
        logic [CNT_W-1:0]  rd_miss_cnt;
        logic [CNT_W-1:0]  wr_cnt;
        logic [CNT_W-1:0]  wr_miss_cnt;
        logic [CNT_W-1:0]  wb_cnt;
    } t_outcome;

    typedef struct {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic              check_hit;
        logic              hit;
        logic              check_wb;
        logic              wb_req;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = CFG_INDEX_BITS;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_operation = OP_READ;
    logic [ADDR_W-1:0] i_address = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_hit, o_fill_request, o_writeback_request;
    logic [ADDR_W-1:0] o_fill_address, o_writeback_address;
    logic [CNT_W-1:0] o_read_count, o_read_miss_count, o_write_count;
    logic [CNT_W-1:0] o_write_miss_count, o_writeback_count;

    set_assoc_lru_writeback_cache_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Predicted tag store.
    logic [ADDR_W-1:0] tag_mem  [SETS*WAYS];
    logic [ADDR_W-1:0] addr_mem [SETS*WAYS];
    logic              valid_mem[SETS*WAYS];
    logic              dirty_mem[SETS*WAYS];
    int unsigned       rank_mem [SETS*WAYS];
    logic [CNT_W-1:0]  rd_cnt, rd_miss_cnt, wr_cnt, wr_miss_cnt, wb_cnt;
    logic [CFG_W-1:0]  cfg_set_bits, offset_bits;

    t_outcome pending_outcomes[$];
    t_row     pending_rows[$];
    int       errors = 0;
    int       idle_cycles = 0;
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    bit       hold_off = 0;

    function automatic t_outcome cache_access(logic op, logic [ADDR_W-1:0] addr);
        t_outcome res;
        int unsigned set, base, way, line, r, sh;
        logic [ADDR_W-1:0] tag;
        logic found;
        set = ((addr >> offset_bits) & ((32'd1 << cfg_set_bits) - 1)) % SETS;
        sh = cfg_set_bits + offset_bits;
        tag = (sh >= 32) ? '0 : addr >> sh;
        base = set * WAYS;
        way = WAYS - 1;
        found = 1'b0;
        res = '0;
        for (int w = 0; w < WAYS; w++)
            if (!found && valid_mem[base+w] && tag_mem[base+w] == tag) begin
                found = 1'b1;
                way = w;
            end
        if (!found)
            for (int w = WAYS - 1; w >= 0; w--)
                if (rank_mem[base+w] == WAYS - 1) way = w;
        line = base + way;
        r = rank_mem[line];
        for (int w = 0; w < WAYS; w++)
            if (rank_mem[base+w] < r) rank_mem[base+w]++;
        rank_mem[line] = 0;
        if (op == OP_WRITE) wr_cnt++;
        else rd_cnt++;
        if (!found) begin
            if (op == OP_WRITE) wr_miss_cnt++;
            else rd_miss_cnt++;
            if (valid_mem[line] && dirty_mem[line]) begin
                res.wb_req = 1'b1;
                res.wb_addr = addr_mem[line];
                wb_cnt++;
            end
            dirty_mem[line] = 1'b0;
            res.fill_req = 1'b1;
            res.fill_addr = addr;
        end
        if (op == OP_WRITE) dirty_mem[line] = 1'b1;
        valid_mem[line] = 1'b1;
        tag_mem[line] = tag;
        addr_mem[line] = addr;
        res.hit = found;
        res.rd_cnt = rd_cnt;
        res.rd_miss_cnt = rd_miss_cnt;
        res.wr_cnt = wr_cnt;
        res.wr_miss_cnt = wr_miss_cnt;
        res.wb_cnt = wb_cnt;
        return res;
    endfunction

    task automatic send_access(logic op, logic [ADDR_W-1:0] addr);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_address <= addr;
        do @(posedge i_clk); while (o_stall);
        pending_outcomes.push_back(cache_access(op, addr));
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        i_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_INDEX_BITS) cfg_set_bits = val;
        else offset_bits = val;
    endtask

    // Receiver stall and result checking.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                t_outcome exp_res, act;
                act = {o_hit, o_fill_request, o_fill_address, o_writeback_request,
                       o_writeback_address, o_read_count, o_read_miss_count,
                       o_write_count, o_write_miss_count, o_writeback_count};
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, act);
                    errors++;
                end else begin
                    exp_res = pending_outcomes.pop_front();
                    if (act !== exp_res) begin
                        $display("%0t: mismatch expected %h actual %h", $realtime,
                                 exp_res, act);
                        errors++;
                    end
                end
                if (pending_rows.size() != 0) begin
                    t_row row;
                    row = pending_rows.pop_front();
                    if ((row.check_hit && o_hit !== row.hit) ||
                        (row.check_wb && o_writeback_request !== row.wb_req)) begin
                        $display("%0t: table row expected hit %b wb %b actual hit %b wb %b",
                                 $realtime, row.hit, row.wb_req, o_hit,
                                 o_writeback_request);
                        errors++;
                    end
                end
            end
            i_stall <= hold_off || (stall_pct > 0 && $urandom_range(99) < stall_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Pressure: the receiver holds off for a long stretch while the sender keeps going.
    task automatic long_hold_off();
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    t_row dir_rows[$];

    initial begin
        logic [ADDR_W-1:0] hot[16];
        for (int i = 0; i < SETS*WAYS; i++) begin
            valid_mem[i] = 1'b0;
            dirty_mem[i] = 1'b0;
            rank_mem[i] = i % WAYS;
            tag_mem[i] = '0;
            addr_mem[i] = '0;
        end
        {rd_cnt, rd_miss_cnt, wr_cnt, wr_miss_cnt, wb_cnt} = '0;
        cfg_set_bits = INDEX_BITS_RST;
        offset_bits = OFFSET_BITS_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: same set (0) filled with five tags evicts the oldest line, then extreme addresses.
        dir_rows = '{
            '{OP_READ,  32'h0000_0000, 1, 0, 1, 0},   // cold miss after reset
            '{OP_READ,  32'h0000_0000, 1, 1, 1, 0},   // same line hits
            '{OP_WRITE, 32'h0000_0800, 1, 0, 1, 0},
            '{OP_WRITE, 32'h0000_1000, 1, 0, 1, 0},
            '{OP_READ,  32'h0000_1800, 1, 0, 1, 0},
            '{OP_WRITE, 32'h0000_0000, 1, 1, 1, 0},   // dirtied, becomes most recent
            '{OP_READ,  32'h0000_2000, 1, 0, 1, 1},   // evicts the dirty line at 0x800
            '{OP_WRITE, 32'hFFFF_FFFF, 1, 0, 1, 0},   // extreme address
            '{OP_READ,  32'hFFFF_FFE0, 1, 1, 1, 0},
            '{OP_WRITE, 32'h0000_001F, 0, 0, 0, 0},
            '{OP_READ,  32'h8000_0000, 0, 0, 0, 0},
            '{OP_WRITE, 32'h5555_5555, 0, 0, 0, 0},
            '{OP_READ,  32'hAAAA_AAAA, 0, 0, 0, 0}
        };
        foreach (dir_rows[i]) begin
            pending_rows.push_back(dir_rows[i]);
            send_access(dir_rows[i].op, dir_rows[i].addr);
        end
        // Extreme settings, including index and offset of zero and the widest.
        write_reg(CFG_INDEX_BITS, 4'd0);
        write_reg(CFG_OFFSET_BITS, 4'd0);
        send_access(OP_WRITE, 32'h0000_0001);
        send_access(OP_READ, 32'h0000_0001);
        write_reg(CFG_INDEX_BITS, 4'd15);   // index wider than the set count
        write_reg(CFG_OFFSET_BITS, 4'd15);
        send_access(OP_WRITE, 32'hFFFF_FFFF);
        send_access(OP_READ, 32'h7FFF_8000);
        send_access(OP_READ, 32'hFFFF_FFFF);

        // Random phases: each setting and idling mix, with small hot address pools
        // so that hits, evictions and dirty writebacks are frequent.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_INDEX_BITS, 4'd2); write_reg(CFG_OFFSET_BITS, 4'd4); end
                1: begin write_reg(CFG_INDEX_BITS, 4'd8); write_reg(CFG_OFFSET_BITS, 4'd12); end
                2: begin write_reg(CFG_INDEX_BITS, 4'd0); write_reg(CFG_OFFSET_BITS, 4'd3); end
                3: begin write_reg(CFG_INDEX_BITS, 4'd6); write_reg(CFG_OFFSET_BITS, 4'd5); end
                4: begin write_reg(CFG_INDEX_BITS, 4'd9); write_reg(CFG_OFFSET_BITS, 4'd0); end
                default: begin write_reg(CFG_INDEX_BITS, 4'd1); write_reg(CFG_OFFSET_BITS, 4'd7); end
            endcase
            send_idle_pct = (ph == 1 || ph == 4) ? 85 : (ph == 3 ? 25 : 0);
            stall_pct     = (ph == 2 || ph == 4) ? 85 : (ph == 3 ? 25 : 0);
            foreach (hot[k]) hot[k] = $urandom();
            fork
                if (ph == 0) long_hold_off();
                for (int n = 0; n < 150; n++) begin
                    logic [ADDR_W-1:0] a;
                    if ($urandom_range(9) < 8)
                        a = hot[$urandom_range(15)] ^ $urandom_range(3);
                    else
                        a = $urandom();
                    send_access(1'($urandom_range(1)), a);
                end
            join
        end
        i_valid <= 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: set_assoc_lru_writeback_cache_top.f
+incdir+rtl
rtl/salwc_pkg.sv
rtl/salwc_front.sv
rtl/salwc_queue.sv
rtl/salwc_back.sv
rtl/set_assoc_lru_writeback_cache_top.sv
tb/set_assoc_lru_writeback_cache_top_tb.sv
